>>> hdl/w16a_pkg.sv
package w16a_pkg;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages = DivSteps / StepsPerStage;

  typedef enum logic [3:0] {
    OpNonBasic = 4'd0,
    OpSet      = 4'd1,
    OpAdd      = 4'd2,
    OpSub      = 4'd3,
    OpMul      = 4'd4,
    OpDiv      = 4'd5,
    OpMod      = 4'd6,
    OpShl      = 4'd7,
    OpShr      = 4'd8,
    OpAnd      = 4'd9,
    OpBor      = 4'd10,
    OpXor      = 4'd11,
    OpIfe      = 4'd12,
    OpIfn      = 4'd13,
    OpIfg      = 4'd14,
    OpIfb      = 4'd15
  } op_e;

  localparam logic [5:0] NbJsr = 6'd1;

  typedef struct packed {
    logic        vld;
    logic        div_op;
    logic        mod_op;
    logic        b_zero;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] part;
    logic [31:0] quo;
    logic [15:0] modv;
    logic [15:0] wval;
    logic        wen;
    logic [15:0] oval;
    logic        oen;
    logic        skip;
    logic        jump;
    logic [15:0] jtgt;
    logic [15:0] push;
    logic [1:0]  extra;
    logic        bad;
  } pl_t;

  function automatic logic [1:0] extra_cycles(input op_e op);
    logic [1:0] r;
    case (op)
      OpSet, OpAnd, OpBor, OpXor: r = 2'd0;
      OpDiv, OpMod:               r = 2'd2;
      OpNonBasic:                 r = 2'd0;
      default:                    r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/word16_alu_execute.sv
// Execute unit for a 16-bit word instruction set on resolved operands.
// A request is taken at a rising edge where start_i is high and busy_o low.
// busy_o is always low: the unit is a pipeline that takes one request every
// cycle and keeps no state between requests.
// Each request gives exactly one result, shown on the result ports for one
// cycle with done_o high, after the input, divider and final registers.
// Results come out in request order, one per cycle at most.
// The depth is set by the divider: a 32-step restoring division of a
// shifted left by sixteen over b, four steps in each of eight stages, after
// an input stage that does every other operation, including the multiply.
// A final register selects the quotient or remainder for DIV and MOD.
// Reset empties the pipeline; requests in flight are dropped.
// The receiver cannot stall, so nothing holds a result back.
module word16_alu_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  cmd_i,
  input  logic [5:0]  nonbasic_op_i,
  input  logic [15:0] a_value_i,
  input  logic [15:0] b_value_i,
  input  logic [15:0] return_address_i,
  output logic        done_o,
  output logic [15:0] write_value_o,
  output logic        write_enable_o,
  output logic [15:0] overflow_value_o,
  output logic        overflow_enable_o,
  output logic        skip_next_o,
  output logic        jump_o,
  output logic [15:0] jump_target_o,
  output logic [15:0] push_value_o,
  output logic [1:0]  extra_cycles_o,
  output logic        bad_opcode_o
);
  import w16a_pkg::*;

  pl_t         in_d;
  pl_t         in_q;
  pl_t         pipe [DivStages+1];
  pl_t         last;
  logic        done_q;
  logic [15:0] wval_d, wval_q, oval_d, oval_q;
  pl_t         res_q;

  assign busy_o = 1'b0;

  always_comb begin
    logic [31:0] prod;
    logic [31:0] shl;
    logic [31:0] shr;
    logic        wide;
    op_e         op;
    op     = op_e'(cmd_i);
    prod   = a_value_i * b_value_i;
    wide   = (b_value_i[15:5] != 11'd0);
    shl    = {16'd0, a_value_i} << b_value_i[4:0];
    shr    = {a_value_i, 16'd0} >> b_value_i[4:0];
    in_d        = '0;
    in_d.vld    = start_i;
    in_d.a      = a_value_i;
    in_d.b      = b_value_i;
    in_d.div_op = (op == OpDiv);
    in_d.mod_op = (op == OpMod);
    in_d.b_zero = (b_value_i == 16'd0);
    in_d.extra  = extra_cycles(op);
    case (op)
      OpNonBasic: begin
        if (nonbasic_op_i == NbJsr) begin
          in_d.jump  = 1'b1;
          in_d.jtgt  = a_value_i;
          in_d.push  = return_address_i;
          in_d.extra = 2'd1;
        end else begin
          in_d.bad = 1'b1;
        end
      end
      OpSet: begin
        in_d.wval = b_value_i;
        in_d.wen  = 1'b1;
      end
      OpAdd: begin
        {in_d.oval, in_d.wval} = {15'd0, {1'b0, a_value_i} + {1'b0, b_value_i}};
        in_d.wen = 1'b1;
        in_d.oen = 1'b1;
      end
      OpSub: begin
        in_d.wval = a_value_i - b_value_i;
        in_d.oval = (a_value_i < b_value_i) ? 16'hffff : 16'd0;
        in_d.wen  = 1'b1;
        in_d.oen  = 1'b1;
      end
      OpMul: begin
        {in_d.oval, in_d.wval} = prod;
        in_d.wen = 1'b1;
        in_d.oen = 1'b1;
      end
      OpDiv: begin
        in_d.wen = 1'b1;
        in_d.oen = 1'b1;
      end
      OpMod: begin
        in_d.wen = 1'b1;
      end
      OpShl: begin
        {in_d.oval, in_d.wval} = wide ? 32'd0 : shl;
        in_d.wen = 1'b1;
        in_d.oen = 1'b1;
      end
      OpShr: begin
        {in_d.wval, in_d.oval} = wide ? 32'd0 : shr;
        in_d.wen = 1'b1;
        in_d.oen = 1'b1;
      end
      OpAnd: begin
        in_d.wval = a_value_i & b_value_i;
        in_d.wen  = 1'b1;
      end
      OpBor: begin
        in_d.wval = a_value_i | b_value_i;
        in_d.wen  = 1'b1;
      end
      OpXor: begin
        in_d.wval = a_value_i ^ b_value_i;
        in_d.wen  = 1'b1;
      end
      OpIfe: in_d.skip = (a_value_i != b_value_i);
      OpIfn: in_d.skip = (a_value_i == b_value_i);
      OpIfg: in_d.skip = (a_value_i <= b_value_i);
      default: in_d.skip = ((a_value_i & b_value_i) == 16'd0);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else begin
      in_q <= in_d;
    end
  end

  assign pipe[0] = in_q;

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    w16a_div_stage #(
      .StageIdx(k)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (pipe[k]),
      .q_o    (pipe[k+1])
    );
  end

  assign last = pipe[DivStages];

  always_comb begin
    wval_d = last.wval;
    oval_d = last.oval;
    if (last.div_op) begin
      wval_d = last.b_zero ? 16'd0 : last.quo[31:16];
      oval_d = last.b_zero ? 16'd0 : last.quo[15:0];
    end else if (last.mod_op) begin
      wval_d = last.b_zero ? 16'd0 : last.modv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    wval_q <= wval_d;
    oval_q <= oval_d;
    res_q  <= last;
  end

  assign done_o            = done_q;
  assign write_value_o     = wval_q;
  assign write_enable_o    = res_q.wen;
  assign overflow_value_o  = oval_q;
  assign overflow_enable_o = res_q.oen;
  assign skip_next_o       = res_q.skip;
  assign jump_o            = res_q.jump;
  assign jump_target_o     = res_q.jtgt;
  assign push_value_o      = res_q.push;
  assign extra_cycles_o    = res_q.extra;
  assign bad_opcode_o      = res_q.bad;

endmodule

>>> hdl/w16a_div_stage.sv
module w16a_div_stage #(
  parameter int unsigned StageIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  w16a_pkg::pl_t d_i,
  output w16a_pkg::pl_t q_o
);
  import w16a_pkg::*;

  pl_t         nxt;
  pl_t         stage_q;

  always_comb begin
    logic [16:0] r;
    logic        bit_in;
    int unsigned step;
    nxt = d_i;
    r   = {1'b0, d_i.part};
    for (int unsigned j = 0; j < StepsPerStage; j++) begin
      step   = StageIdx * StepsPerStage + j;
      bit_in = (step < 16) ? d_i.a[4'(15 - step)] : 1'b0;
      r      = {r[15:0], bit_in};
      if (r >= {1'b0, d_i.b}) begin
        r       = r - {1'b0, d_i.b};
        nxt.quo = {nxt.quo[30:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[30:0], 1'b0};
      end
      if (step == 15) begin
        nxt.modv = r[15:0];
      end
    end
    nxt.part = r[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= nxt;
    end
  end

  assign q_o = stage_q;

endmodule

>>> hdl/w16a_checker.sv
module w16a_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        write_enable_o,
  input logic        overflow_enable_o,
  input logic        skip_next_o,
  input logic        jump_o,
  input logic [1:0]  extra_cycles_o,
  input logic        bad_opcode_o
);
  localparam int unsigned Latency = 10;

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("request gave no result");

  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without request");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_opcode_o) |-> (!write_enable_o && !overflow_enable_o && !jump_o &&
                                  !skip_next_o && extra_cycles_o == 2'd0))
    else $error("invalid opcode had side effects");

  a_skip_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && skip_next_o) |-> (!write_enable_o && !overflow_enable_o && !jump_o))
    else $error("skip with write-back");

endmodule

bind word16_alu_execute w16a_checker u_w16a_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .write_enable_o    (write_enable_o),
  .overflow_enable_o (overflow_enable_o),
  .skip_next_o       (skip_next_o),
  .jump_o            (jump_o),
  .extra_cycles_o    (extra_cycles_o),
  .bad_opcode_o      (bad_opcode_o)
);
